[rtl/prfia_pkg.sv]
package prfia_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = 7;
    localparam int VAL_W     = 16;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // take one input transaction
        logic mark_rd;    // read holder table at v, advance v
        logic v_rst;      // rewind v to one
        logic free_step;  // one step of the free-value hand-out
        logic emit_rd;    // read assigned table at p
        logic emit_next;  // advance p after an output transaction
        logic clear;      // clear tables for the next list
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic v_last;     // v equals list length
        logic free_adv;   // free step moved on to the next value
        logic p_last;     // p equals list length
    } sts_t;

endpackage

[rtl/prfia_ctrl.sv]
module prfia_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             last_item,
    input  logic             out_stall,
    input  prfia_pkg::sts_t  sts,
    output prfia_pkg::cmd_t  cmd,
    output logic             in_stall,
    output logic             out_valid
);
    import prfia_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_MARK  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_FREE  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_SHOW  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_item)
                    begin
                        state_next = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                cmd.mark_rd = 1'b1;
                if (sts.v_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last marking write lands here
                cmd.v_rst  = 1'b1;
                state_next = S_FREE;
            end
            S_FREE:
            begin
                cmd.free_step = 1'b1;
                if (sts.free_adv && sts.v_last)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_SHOW;
            end
            S_SHOW:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.emit_next = 1'b1;
                    if (sts.p_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

[rtl/prfia_dpath.sv]
module prfia_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prfia_pkg::cmd_t               cmd,
    input  logic [prfia_pkg::VAL_W-1:0]   item_value,
    output prfia_pkg::sts_t               sts,
    output logic [prfia_pkg::CNT_W-1:0]   position,
    output logic [prfia_pkg::CNT_W-1:0]   new_value,
    output logic                          end_of_list
);
    import prfia_pkg::*;

    cnt_t holder_mem [MAX_ITEMS];
    cnt_t assigned_mem [MAX_ITEMS];

    logic [MAX_ITEMS-1:0] holder_vld_reg;
    logic [MAX_ITEMS-1:0] holder_vld_next;
    logic [MAX_ITEMS-1:0] kept_reg;
    logic [MAX_ITEMS-1:0] kept_next;

    cnt_t cnt_reg, cnt_next;
    cnt_t v_reg, v_next;
    cnt_t lfp_reg, lfp_next;
    cnt_t p_reg, p_next;

    logic mark_pend_reg;
    logic mark_hit_reg;
    cnt_t mark_v_reg;
    cnt_t holder_q_reg;
    cnt_t rd_data_reg;

    logic [VAL_W-1:0] val_m1;
    logic             val_in_range;
    logic             room;
    cnt_t             v_m1, lfp_m1, p_m1, q_m1;
    idx_t             v_idx, lfp_idx, p_idx, q_idx, load_idx;
    logic             lfp_ok;
    logic             v_held;
    logic             lfp_kept;
    logic             free_adv;

    logic             asg_we;
    idx_t             asg_addr;
    cnt_t             asg_data;
    logic             hold_we;

    assign val_m1       = item_value - VAL_W'(1);
    assign val_in_range = (item_value != '0) && (item_value <= VAL_W'(MAX_ITEMS));
    assign load_idx     = val_m1[IDX_W-1:0];
    assign room         = cnt_reg < CNT_W'(MAX_ITEMS);

    assign v_m1    = v_reg - CNT_W'(1);
    assign lfp_m1  = lfp_reg - CNT_W'(1);
    assign p_m1    = p_reg - CNT_W'(1);
    assign q_m1    = holder_q_reg - CNT_W'(1);
    assign v_idx   = v_m1[IDX_W-1:0];
    assign lfp_idx = lfp_m1[IDX_W-1:0];
    assign p_idx   = p_m1[IDX_W-1:0];
    assign q_idx   = q_m1[IDX_W-1:0];

    // a recorded holder never exceeds the final length, so a valid entry is kept
    assign v_held   = holder_vld_reg[v_idx];
    assign lfp_ok   = lfp_reg <= cnt_reg;
    assign lfp_kept = kept_reg[lfp_idx];

    assign hold_we = cmd.load && room && val_in_range;

    always_comb
    begin
        holder_vld_next = holder_vld_reg;
        kept_next       = kept_reg;
        cnt_next        = cnt_reg;
        v_next          = v_reg;
        lfp_next        = lfp_reg;
        p_next          = p_reg;
        asg_we          = 1'b0;
        asg_addr        = q_idx;
        asg_data        = mark_v_reg;
        free_adv        = 1'b0;

        if (cmd.load && room)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (val_in_range)
            begin
                holder_vld_next[load_idx] = 1'b1;
            end
        end

        if (cmd.mark_rd)
        begin
            v_next = v_reg + CNT_W'(1);
        end

        if (mark_pend_reg && mark_hit_reg)
        begin
            asg_we           = 1'b1;
            kept_next[q_idx] = 1'b1;
        end

        if (cmd.free_step)
        begin
            if (v_held)
            begin
                free_adv = 1'b1;
            end
            else if (lfp_ok && lfp_kept)
            begin
                lfp_next = lfp_reg + CNT_W'(1);
            end
            else
            begin
                free_adv = 1'b1;
                if (lfp_ok)
                begin
                    asg_we             = 1'b1;
                    asg_addr           = lfp_idx;
                    asg_data           = v_reg;
                    kept_next[lfp_idx] = 1'b1;
                end
            end
            if (free_adv)
            begin
                v_next = v_reg + CNT_W'(1);
            end
        end

        if (cmd.v_rst)
        begin
            v_next = CNT_W'(1);
        end

        if (cmd.emit_next)
        begin
            p_next = p_reg + CNT_W'(1);
        end

        if (cmd.clear)
        begin
            holder_vld_next = '0;
            kept_next       = '0;
            cnt_next        = '0;
            v_next          = CNT_W'(1);
            lfp_next        = CNT_W'(1);
            p_next          = CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holder_vld_reg <= '0;
            kept_reg       <= '0;
            cnt_reg        <= '0;
            v_reg          <= CNT_W'(1);
            lfp_reg        <= CNT_W'(1);
            p_reg          <= CNT_W'(1);
            mark_pend_reg  <= 1'b0;
        end
        else
        begin
            holder_vld_reg <= holder_vld_next;
            kept_reg       <= kept_next;
            cnt_reg        <= cnt_next;
            v_reg          <= v_next;
            lfp_reg        <= lfp_next;
            p_reg          <= p_next;
            mark_pend_reg  <= cmd.mark_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_we)
        begin
            holder_mem[load_idx] <= cnt_reg + CNT_W'(1);
        end
        if (cmd.mark_rd)
        begin
            holder_q_reg <= holder_mem[v_idx];
            mark_hit_reg <= v_held;
            mark_v_reg   <= v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (asg_we)
        begin
            assigned_mem[asg_addr] <= asg_data;
        end
        if (cmd.emit_rd)
        begin
            rd_data_reg <= assigned_mem[p_idx];
        end
    end

    assign sts.free_adv = free_adv;
    assign sts.v_last   = v_reg == cnt_reg;
    assign sts.p_last   = p_reg == cnt_reg;

    assign position    = p_reg;
    assign new_value   = rd_data_reg;
    assign end_of_list = p_reg == cnt_reg;

endmodule

[rtl/permutation_repair_free_id_assign.sv]
// Channel | Handshake            | Fields
// --------+----------------------+-----------------------------------
// in      | in_valid / in_stall  | item_value[15:0], last_item
// out     | out_valid / out_stall| position[6:0], new_value[6:0], end_of_list
//
// Loading accepts one input transaction per cycle; items past 64 are dropped.
// After the last item: marking, then hand-out (one value or one free-position
// skip per cycle), then each result is read through the registered read port of
// the assigned-value memory before it is shown, so results never come back to back.
// Reset (rst_n, asynchronous) clears the controller and the table valid bits.
// Input is stalled from the last item until the final result is taken;
// out_stall holds the current result and its payload.
module permutation_repair_free_id_assign (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [prfia_pkg::VAL_W-1:0]   item_value,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [prfia_pkg::CNT_W-1:0]   position,
    output logic [prfia_pkg::CNT_W-1:0]   new_value,
    output logic                          end_of_list
);
    import prfia_pkg::*;

    cmd_t cmd;
    sts_t sts;

    prfia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_item (last_item),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    prfia_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item_value  (item_value),
        .sts         (sts),
        .position    (position),
        .new_value   (new_value),
        .end_of_list (end_of_list)
    );

    a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while results pending");

    a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && end_of_list |=> !in_stall && !out_valid)
        else $error("block did not return to loading after last result");

    a_gap_between_results: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !end_of_list |=> !out_valid && in_stall)
        else $error("result read sequencing broken");

    a_position_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position != '0 && new_value != '0)
        else $error("result carries zero position or value");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import prfia_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned TAIL_CYCLES = 60;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             last;
        int unsigned      gap;
        bit               drain;
    } id_entry_t;

    typedef struct packed {
        logic [CNT_W-1:0] position;
        logic [CNT_W-1:0] new_value;
        logic             end_of_list;
    } renumber_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic [VAL_W-1:0] item_value  = '0;
    logic             last_item   = 1'b0;
    logic             out_stall   = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] new_value;
    logic             end_of_list;

    id_entry_t   id_feed[$];
    renumber_t   due_ids[$];

    // predictor state
    logic [CNT_W-1:0] holder_tab   [1:MAX_ITEMS];
    bit               kept_tab     [1:MAX_ITEMS];
    logic [CNT_W-1:0] assigned_tab [1:MAX_ITEMS];
    int unsigned      list_len;
    int unsigned      free_ptr;

    int unsigned feed_gap;
    int unsigned hold_left;
    int unsigned cycle_cnt;
    int unsigned error_cnt;
    int unsigned ids_sent;
    int unsigned ids_checked;
    int unsigned lists_done;
    int unsigned longest_list;

    permutation_repair_free_id_assign uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .item_value  (item_value),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .new_value   (new_value),
        .end_of_list (end_of_list)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned s;
        s = $urandom_range(0, 19);
        if (s < 12)
            return 0;
        if (s < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic clear_tables();
        for (int i = 1; i <= MAX_ITEMS; i++)
        begin
            holder_tab[i] = '0;
            kept_tab[i]   = 1'b0;
        end
        list_len = 0;
        free_ptr = 1;
    endtask

    task automatic renumber_item(input logic [VAL_W-1:0] val, input logic lst);
        int unsigned n;
        int unsigned p;
        renumber_t   r;
        if (list_len < MAX_ITEMS)
        begin
            list_len++;
            if (val >= 1 && val <= MAX_ITEMS)
                holder_tab[val] = CNT_W'(list_len);
        end
        if (lst)
        begin
            n = list_len;
            for (int v = 1; v <= n; v++)
            begin
                p = holder_tab[v];
                if (p >= 1 && p <= n)
                    kept_tab[p] = 1'b1;
            end
            // kept values stay put, absent values fill the lowest free slots
            for (int v = 1; v <= n; v++)
            begin
                p = holder_tab[v];
                if (p >= 1 && p <= n)
                    assigned_tab[p] = CNT_W'(v);
                else
                begin
                    while (free_ptr <= n && kept_tab[free_ptr])
                        free_ptr++;
                    if (free_ptr <= n)
                    begin
                        assigned_tab[free_ptr] = CNT_W'(v);
                        kept_tab[free_ptr]     = 1'b1;
                    end
                end
            end
            for (int q = 1; q <= n; q++)
            begin
                r.position    = CNT_W'(q);
                r.new_value   = assigned_tab[q];
                r.end_of_list = (q == n);
                due_ids.insert(due_ids.size(), r);
            end
            lists_done++;
            if (n > longest_list)
                longest_list = n;
            clear_tables();
        end
    endtask

    task automatic queue_id(input logic [VAL_W-1:0] val, input logic lst, input bit burst);
        id_entry_t e;
        e.value = val;
        e.last  = lst;
        e.gap   = burst ? 0 : pick_gap();
        e.drain = 1'b0;
        id_feed.insert(id_feed.size(), e);
    endtask

    task automatic queue_drain();
        id_entry_t e;
        e.value = '0;
        e.last  = 1'b0;
        e.gap   = 0;
        e.drain = 1'b1;
        id_feed.insert(id_feed.size(), e);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            item_value <= '0;
            last_item  <= 1'b0;
            feed_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                renumber_item(item_value, last_item);
                ids_sent++;
            end
            if (!(in_valid && in_stall))
            begin
                if (feed_gap > 0)
                begin
                    in_valid <= 1'b0;
                    feed_gap <= feed_gap - 1;
                end
                else if (id_feed.size() != 0)
                begin
                    if (id_feed[0].drain)
                    begin
                        // hold off until every pending result is out
                        in_valid <= 1'b0;
                        if (due_ids.size() == 0)
                            void'(id_feed.pop_front());
                    end
                    else
                    begin
                        in_valid   <= 1'b1;
                        item_value <= id_feed[0].value;
                        last_item  <= id_feed[0].last;
                        feed_gap   <= id_feed[0].gap;
                        void'(id_feed.pop_front());
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        renumber_t got;
        renumber_t exp;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{position, new_value, end_of_list};
                if (due_ids.size() == 0)
                begin
                    error_cnt++;
                    $display("%0t: unexpected transaction position/new_value/end_of_list %0d/%0d/%0d",
                             $time, got.position, got.new_value, got.end_of_list);
                end
                else
                begin
                    exp = due_ids.pop_front();
                    ids_checked++;
                    if (got !== exp)
                    begin
                        error_cnt++;
                        $display("%0t: position/new_value/end_of_list expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, exp.position, exp.new_value, exp.end_of_list,
                                 got.position, got.new_value, got.end_of_list);
                    end
                end
            end
            // regular quiet stretch with no output stall, set by cycle_cnt
            if ((cycle_cnt % 1024) < 256)
                out_stall <= 1'b0;
            else if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                hold_left <= pick_gap();
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_cnt, due_ids.size());
            $display("[permutation_repair_free_id_assign] ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned random_sent;
        int unsigned n;
        int unsigned s;
        bit          burst;
        bit          drained;
        logic [VAL_W-1:0] val;

        cycle_cnt    = 0;
        error_cnt    = 0;
        ids_sent     = 0;
        ids_checked  = 0;
        lists_done   = 0;
        longest_list = 0;
        random_sent  = 0;
        drained      = 1'b0;
        clear_tables();
        for (int i = 1; i <= MAX_ITEMS; i++)
            assigned_tab[i] = '0;

        // single-entry lists: out of table, and kept
        queue_id(16'hFFFF, 1'b1, 1'b0);
        queue_id(16'd1, 1'b1, 1'b0);
        // duplicates, zero and just-above-table values
        queue_id(16'd3, 1'b0, 1'b0);
        queue_id(16'd3, 1'b0, 1'b0);
        queue_id(16'd0, 1'b0, 1'b0);
        queue_id(16'd65, 1'b0, 1'b0);
        queue_id(16'd1, 1'b1, 1'b0);
        // swapped pair, all kept
        queue_id(16'd2, 1'b0, 1'b1);
        queue_id(16'd1, 1'b1, 1'b1);
        // values above list length
        queue_id(16'd64, 1'b0, 1'b0);
        queue_id(16'd40, 1'b0, 1'b0);
        queue_id(16'd7, 1'b1, 1'b0);
        // alternating and single-bit patterns, all out of table
        queue_id(16'hAAAA, 1'b0, 1'b0);
        queue_id(16'h5555, 1'b0, 1'b0);
        queue_id(16'h8000, 1'b1, 1'b0);
        // all the same value
        for (int k = 1; k <= 4; k++)
            queue_id(16'd1, k == 4, 1'b0);
        queue_drain();
        // overlong list: reversed full permutation, then dropped transactions
        // with the last marker on the final dropped one
        for (int k = 1; k <= MAX_ITEMS + 3; k++)
        begin
            if (k <= MAX_ITEMS)
                val = VAL_W'(MAX_ITEMS + 1 - k);
            else
                val = VAL_W'($urandom_range(1, MAX_ITEMS));
            queue_id(val, k == MAX_ITEMS + 3, k <= MAX_ITEMS / 2);
        end
        queue_drain();

        while (random_sent < 20)
        begin
            s = $urandom_range(0, 19);
            if (s == 0)
                n = $urandom_range(21, 32);
            else if (s < 5)
                n = $urandom_range(9, 20);
            else
                n = $urandom_range(1, 8);
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 1; k <= n; k++)
            begin
                s = $urandom_range(0, 19);
                if (s < 14)
                    val = VAL_W'($urandom_range(1, n));
                else if (s < 16)
                    val = VAL_W'($urandom_range(1, MAX_ITEMS));
                else if (s < 17)
                    val = '0;
                else
                    val = VAL_W'($urandom_range(0, 16'hFFFF));
                queue_id(val, k == n, burst);
            end
            random_sent += n;
            if (random_sent >= 10 && !drained)
            begin
                queue_drain();
                drained = 1'b1;
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (id_feed.size() != 0 || in_valid || due_ids.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d ids in %0d lists (longest %0d), checked %0d renumbered positions",
                 ids_sent, lists_done, longest_list, ids_checked);
        $display("Covered out-of-table values, duplicates, overlong lists and stall/idle gaps");
        if (error_cnt == 0 && due_ids.size() == 0)
            $display("[permutation_repair_free_id_assign] OK");
        else
            $display("[permutation_repair_free_id_assign] ERROR");
        $finish;
    end

endmodule
